### rtl/core/pvkt_pkg.sv
// Shared constants and port widths for the position/velocity Kalman tracker.
package pvkt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TIME_WIDTH = 32;
   localparam int VAL_W = 32;

   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 24;

   // request kinds
   localparam logic [1:0] REQ_MEAS  = 2'd0;
   localparam logic [1:0] REQ_MARK  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MEAS_DEV   = 2'd0;
   localparam logic [1:0] CSR_DEV_MARGIN = 2'd1;
   localparam logic [1:0] CSR_RESET_GAP  = 2'd2;
   localparam logic [1:0] CSR_DEV_LIMIT  = 2'd3;

   localparam logic [23:0] MEAS_DEV_RST   = 24'd6554;
   localparam logic [23:0] DEV_MARGIN_RST = 24'd9830;
   localparam logic [15:0] RESET_GAP_RST  = 16'd1000;
   localparam logic [7:0]  DEV_LIMIT_RST  = 8'd3;

   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage

### rtl/core/position_velocity_kalman_tracker.sv
// Constant-velocity Kalman tracker with one shared multiplier, divider and square root.
//
// Requests enter on the req_ stream: tuser carries the kind (measurement, mark
// target not visible, query and read), tdata carries x, y and the timestamp.
// Every request gives exactly one result beat on the rsp_ stream: filtered
// position and velocity in tdata, reacquired and hard_deviation in tuser.
// Mark, query and re-acquiring measurements finish in the accept cycle; the
// result is valid on the next cycle. A tracking measurement runs a sequencer
// over one 33x33 multiplier (28 operations, each a multiply state and an
// accumulate state), a restoring divider (for dt, K0 and K1) and a bit-pair
// square root (run twice), then checks the deviation and loads the result beat.
// The block takes one request at a time; req_tready is low while a request
// is in work, and also while a finished result is held because rsp_tready is
// low. The result register holds its beat until it is taken.
// Reset (synchronous, active high) sets the estimate and velocity to zero, the
// covariance to identity, the target to not visible and the registers to defaults.
// The user writes csr_ registers only while the block is idle; it is not enforced.
module position_velocity_kalman_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x [31:0], pos_y [63:32], instant_ms [95:64]
   input  logic [pvkt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type [1:0]
   input  logic [pvkt_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // filt_x [31:0], filt_y [63:32], speed_x [95:64], speed_y [127:96]
   output logic [pvkt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // reacquired [0], hard_deviation [1]
   output logic [pvkt_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_we,
   input  logic [pvkt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pvkt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pvkt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_RUN, S_DIV_END, S_MUL, S_ACC, S_SQRT_RUN, S_CHECK, S_DONE
   } state_type;

   localparam logic [4:0] OP_RN    = 5'd0;
   localparam logic [4:0] OP_D3    = 5'd1;
   localparam logic [4:0] OP_Q00   = 5'd2;
   localparam logic [4:0] OP_Q11   = 5'd3;
   localparam logic [4:0] OP_FP00  = 5'd4;
   localparam logic [4:0] OP_FP01  = 5'd5;
   localparam logic [4:0] OP_T     = 5'd6;
   localparam logic [4:0] OP_PP00  = 5'd7;
   localparam logic [4:0] OP_PP10  = 5'd8;
   localparam logic [4:0] OP_PP11  = 5'd9;
   localparam logic [4:0] OP_S     = 5'd10;
   localparam logic [4:0] OP_PX    = 5'd11;
   localparam logic [4:0] OP_PY    = 5'd12;
   localparam logic [4:0] OP_RX    = 5'd13;
   localparam logic [4:0] OP_RY    = 5'd14;
   localparam logic [4:0] OP_IK0   = 5'd15;
   localparam logic [4:0] OP_C0    = 5'd16;
   localparam logic [4:0] OP_C1    = 5'd17;
   localparam logic [4:0] OP_C2    = 5'd18;
   localparam logic [4:0] OP_C3    = 5'd19;
   localparam logic [4:0] OP_EX    = 5'd20;
   localparam logic [4:0] OP_EY    = 5'd21;
   localparam logic [4:0] OP_VX    = 5'd22;
   localparam logic [4:0] OP_VY    = 5'd23;
   localparam logic [4:0] OP_SQ_EX = 5'd24;
   localparam logic [4:0] OP_SQ_EY = 5'd25;
   localparam logic [4:0] OP_SQ_MX = 5'd26;
   localparam logic [4:0] OP_SQ_MY = 5'd27;

   localparam logic [1:0] JOB_DT = 2'd0;
   localparam logic [1:0] JOB_K0 = 2'd1;
   localparam logic [1:0] JOB_K1 = 2'd2;

   localparam logic signed [65:0] SMAX = 66'sd2147483647;
   localparam logic signed [65:0] SMIN = -66'sd2147483648;
   localparam logic signed [65:0] HALF66 = 66'sd32768;
   localparam logic signed [32:0] RECIP3 = 33'sd11184811;
   localparam logic signed [32:0] ONE33 = 33'sd65536;
   localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MIN32 = 32'sh80000000;
   localparam logic [5:0] DIV_STEPS = 6'd48;
   localparam logic [4:0] SQRT_STEPS = 5'd31;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > SMAX) begin
         return MAX32;
      end else if (v < SMIN) begin
         return MIN32;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      logic signed [31:0] n;
      n = -v;
      return v[31] ? n : v;
   endfunction

   function automatic logic signed [32:0] sx(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   state_type state_ff;
   logic [4:0] op_ff;

   logic [23:0] cfg_dev_ff, cfg_margin_ff;
   logic [15:0] cfg_gap_ff;
   logic [7:0]  cfg_limit_ff;

   logic signed [31:0] est_x_ff, est_y_ff, vel_x_ff, vel_y_ff;
   logic signed [31:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [31:0] last_time_ff;
   logic visible_ff;
   logic [7:0] dev_count_ff;

   logic signed [31:0] mx_ff, my_ff;
   logic signed [31:0] rn_ff, q00_ff, q11_ff, dt_ff, fp00_ff, fp01_ff;
   logic signed [31:0] pp00_ff, pp10_ff, pp11_ff, s_ff, k0_ff, k1_ff;
   logic signed [31:0] px_ff, py_ff, rx_ff, ry_ff, ik0_ff;
   logic [23:0] d3_ff;
   logic signed [65:0] prod_ff;
   logic [63:0] sq_ff;

   logic [48:0] div_num_ff, div_quo_ff;
   logic [31:0] div_den_ff;
   logic [32:0] div_rem_ff;
   logic [5:0]  div_cnt_ff;
   logic div_neg_ff;
   logic [1:0] div_job_ff;

   logic [63:0] sqrt_v_ff, sqrt_r_ff, sqrt_bit_ff;
   logic [4:0]  sqrt_cnt_ff;
   logic sqrt_second_ff;
   logic [31:0] len_e_ff;

   logic rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_USER_W-1:0] rsp_tuser_ff;

   // operand selection
   logic signed [32:0] op_a, op_b;
   logic signed [31:0] op_c;
   logic op_neg;
   logic signed [32:0] d33, d2_33;

   assign d33 = {9'b0, cfg_dev_ff};
   assign d2_33 = {8'b0, cfg_dev_ff, 1'b0};

   always_comb begin
      op_a = '0;
      op_b = '0;
      op_c = '0;
      op_neg = 1'b0;
      case (op_ff)
         OP_RN: begin op_a = d33; op_b = d33; end
         OP_D3: begin op_a = d33; op_b = RECIP3; end
         OP_Q00: begin op_a = {9'b0, d3_ff}; op_b = {9'b0, d3_ff}; end
         OP_Q11: begin op_a = d2_33; op_b = d2_33; end
         OP_FP00: begin op_a = sx(dt_ff); op_b = sx(p10_ff); op_c = p00_ff; end
         OP_FP01: begin op_a = sx(dt_ff); op_b = sx(p11_ff); op_c = p01_ff; end
         OP_T: begin op_a = sx(fp01_ff); op_b = sx(dt_ff); op_c = fp00_ff; end
         OP_PP00: begin op_a = sx(q00_ff); op_b = ONE33; op_c = pp00_ff; end
         OP_PP10: begin op_a = sx(p11_ff); op_b = sx(dt_ff); op_c = p10_ff; end
         OP_PP11: begin op_a = sx(q11_ff); op_b = ONE33; op_c = p11_ff; end
         OP_S: begin op_a = sx(rn_ff); op_b = ONE33; op_c = pp00_ff; end
         OP_PX: begin op_a = sx(dt_ff); op_b = sx(vel_x_ff); op_c = est_x_ff; end
         OP_PY: begin op_a = sx(dt_ff); op_b = sx(vel_y_ff); op_c = est_y_ff; end
         OP_RX: begin op_a = sx(px_ff); op_b = ONE33; op_c = mx_ff; op_neg = 1'b1; end
         OP_RY: begin op_a = sx(py_ff); op_b = ONE33; op_c = my_ff; op_neg = 1'b1; end
         OP_IK0: begin op_a = sx(k0_ff); op_b = ONE33; op_c = Q_ONE; op_neg = 1'b1; end
         OP_C0: begin op_a = sx(ik0_ff); op_b = sx(pp00_ff); end
         OP_C1: begin op_a = sx(ik0_ff); op_b = sx(fp01_ff); end
         OP_C2: begin
            op_a = sx(k1_ff); op_b = sx(pp00_ff); op_c = pp10_ff; op_neg = 1'b1;
         end
         OP_C3: begin
            op_a = sx(k1_ff); op_b = sx(fp01_ff); op_c = pp11_ff; op_neg = 1'b1;
         end
         OP_EX: begin op_a = sx(k0_ff); op_b = sx(rx_ff); op_c = px_ff; end
         OP_EY: begin op_a = sx(k0_ff); op_b = sx(ry_ff); op_c = py_ff; end
         OP_VX: begin op_a = sx(k1_ff); op_b = sx(rx_ff); op_c = vel_x_ff; end
         OP_VY: begin op_a = sx(k1_ff); op_b = sx(ry_ff); op_c = vel_y_ff; end
         OP_SQ_EX: begin op_a = {1'b0, abs32(est_x_ff)}; op_b = op_a; end
         OP_SQ_EY: begin op_a = {1'b0, abs32(est_y_ff)}; op_b = op_a; end
         OP_SQ_MX: begin op_a = {1'b0, abs32(mx_ff)}; op_b = op_a; end
         OP_SQ_MY: begin op_a = {1'b0, abs32(my_ff)}; op_b = op_a; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // shared multiplier and rounding/accumulate stage
   logic signed [65:0] mul_full, rnd, qext, cext, acc_sum;
   logic signed [31:0] qv, acc_res;
   logic [63:0] sq_sum;

   always_comb begin
      mul_full = op_a * op_b;
      rnd = prod_ff + HALF66;
      qv = sat32(rnd >>> FRAC_BITS);
      qext = 66'(qv);
      cext = 66'(op_c);
      acc_sum = op_neg ? (cext - qext) : (cext + qext);
      acc_res = sat32(acc_sum);
      sq_sum = sq_ff + prod_ff[63:0];
   end

   // leave the multiply loop for a divide, a square root or the end
   logic acc_leave;
   assign acc_leave = (op_ff == OP_S) || (op_ff == OP_SQ_EY) || (op_ff > OP_SQ_MX);

   // divider step and result
   logic [32:0] rem_sh, rem_next;
   logic div_ge;
   logic signed [31:0] div_res;
   logic [31:0] quo_lo;

   always_comb begin
      rem_sh = {div_rem_ff[31:0], div_num_ff[48]};
      div_ge = rem_sh >= {1'b0, div_den_ff};
      rem_next = div_ge ? (rem_sh - {1'b0, div_den_ff}) : rem_sh;
      quo_lo = div_quo_ff[31:0];
      if (div_job_ff == JOB_DT) begin
         div_res = (div_quo_ff > 49'h7FFFFFFF) ? MAX32 : quo_lo;
      end else if (div_den_ff == 32'd0) begin
         div_res = '0;
      end else if (!div_neg_ff) begin
         div_res = (div_quo_ff > 49'h7FFFFFFF) ? MAX32 : quo_lo;
      end else begin
         div_res = (div_quo_ff > 49'h80000000) ? MIN32 : -quo_lo;
      end
   end

   // square root step
   logic [63:0] sqrt_trial, sqrt_r_next;
   logic sqrt_ge;
   assign sqrt_trial = sqrt_r_ff + sqrt_bit_ff;
   assign sqrt_ge = sqrt_v_ff >= sqrt_trial;
   assign sqrt_r_next = sqrt_ge ? ((sqrt_r_ff >> 1) + sqrt_bit_ff) : (sqrt_r_ff >> 1);

   // deviation test
   logic [31:0] len_diff;
   logic [24:0] dev_thr;
   always_comb begin
      len_diff = (len_e_ff >= sqrt_r_ff[31:0]) ? (len_e_ff - sqrt_r_ff[31:0])
                                              : (sqrt_r_ff[31:0] - len_e_ff);
      dev_thr = {1'b0, cfg_dev_ff} + {1'b0, cfg_margin_ff};
   end

   // request decode
   logic req_fire, out_free, rsp_load;
   logic signed [31:0] in_x, in_y;
   logic [31:0] in_now, in_gap;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire = req_tvalid && req_tready;
   assign in_x = req_tdata[31:0];
   assign in_y = req_tdata[63:32];
   assign in_now = req_tdata[95:64];
   assign in_gap = in_now - last_time_ff;
   assign rsp_load = (req_fire && !(req_tuser == REQ_MEAS && visible_ff)) ||
                     (state_ff == S_DONE && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_RN;
         cfg_dev_ff <= MEAS_DEV_RST;
         cfg_margin_ff <= DEV_MARGIN_RST;
         cfg_gap_ff <= RESET_GAP_RST;
         cfg_limit_ff <= DEV_LIMIT_RST;
         est_x_ff <= '0;
         est_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         p00_ff <= Q_ONE;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= Q_ONE;
         last_time_ff <= '0;
         visible_ff <= 1'b0;
         dev_count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MEAS_DEV: cfg_dev_ff <= csr_wdata;
               CSR_DEV_MARGIN: cfg_margin_ff <= csr_wdata;
               CSR_RESET_GAP: cfg_gap_ff <= csr_wdata[15:0];
               CSR_DEV_LIMIT: cfg_limit_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_tuser)
                     REQ_MEAS: begin
                        last_time_ff <= in_now;
                        if (!visible_ff) begin
                           // re-acquire: pass the position through
                           est_x_ff <= in_x;
                           est_y_ff <= in_y;
                           vel_x_ff <= '0;
                           vel_y_ff <= '0;
                           if (in_gap > {16'b0, cfg_gap_ff}) begin
                              p00_ff <= Q_ONE;
                              p01_ff <= '0;
                              p10_ff <= '0;
                              p11_ff <= Q_ONE;
                           end
                           dev_count_ff <= '0;
                           visible_ff <= 1'b1;
                           rsp_tdata_ff <= {64'b0, in_y, in_x};
                           rsp_tuser_ff <= 2'b01;
                        end else begin
                           mx_ff <= in_x;
                           my_ff <= in_y;
                           div_num_ff <= {1'b0, in_gap, 16'b0} + 49'd500;
                           div_den_ff <= 32'd1000;
                           div_neg_ff <= 1'b0;
                           div_rem_ff <= '0;
                           div_cnt_ff <= DIV_STEPS;
                           div_job_ff <= JOB_DT;
                           state_ff <= S_DIV_RUN;
                        end
                     end
                     REQ_MARK: begin
                        visible_ff <= 1'b0;
                        rsp_tdata_ff <= {vel_y_ff, vel_x_ff, est_y_ff, est_x_ff};
                        rsp_tuser_ff <= '0;
                     end
                     REQ_QUERY: begin
                        rsp_tdata_ff <= {vel_y_ff, vel_x_ff, est_y_ff, est_x_ff};
                        if (dev_count_ff >= cfg_limit_ff) begin
                           dev_count_ff <= '0;
                           rsp_tuser_ff <= 2'b10;
                        end else begin
                           rsp_tuser_ff <= '0;
                        end
                     end
                     default: begin
                        rsp_tdata_ff <= {vel_y_ff, vel_x_ff, est_y_ff, est_x_ff};
                        rsp_tuser_ff <= '0;
                     end
                  endcase
               end
            end

            S_DIV_RUN: begin
               div_rem_ff <= rem_next;
               div_num_ff <= {div_num_ff[47:0], 1'b0};
               div_quo_ff <= {div_quo_ff[47:0], div_ge};
               div_cnt_ff <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd0) begin
                  state_ff <= S_DIV_END;
               end
            end

            S_DIV_END: begin
               case (div_job_ff)
                  JOB_DT: begin
                     dt_ff <= div_res;
                     op_ff <= OP_RN;
                     state_ff <= S_MUL;
                  end
                  JOB_K0: begin
                     k0_ff <= div_res;
                     div_num_ff <= {1'b0, abs32(pp10_ff), 16'b0};
                     div_den_ff <= abs32(s_ff);
                     div_neg_ff <= pp10_ff[31] ^ s_ff[31];
                     div_rem_ff <= '0;
                     div_cnt_ff <= DIV_STEPS;
                     div_job_ff <= JOB_K1;
                     state_ff <= S_DIV_RUN;
                  end
                  default: begin
                     k1_ff <= div_res;
                     op_ff <= OP_PX;
                     state_ff <= S_MUL;
                  end
               endcase
            end

            S_MUL: begin
               prod_ff <= mul_full;
               state_ff <= S_ACC;
            end

            S_ACC: begin
               op_ff <= op_ff + 5'd1;
               if (!acc_leave) begin
                  state_ff <= S_MUL;
               end
               case (op_ff)
                  OP_RN: rn_ff <= qv;
                  OP_D3: d3_ff <= prod_ff[48:25];
                  OP_Q00: q00_ff <= qv;
                  OP_Q11: q11_ff <= qv;
                  OP_FP00: fp00_ff <= acc_res;
                  OP_FP01: fp01_ff <= acc_res;
                  OP_T: pp00_ff <= acc_res;
                  OP_PP00: pp00_ff <= acc_res;
                  OP_PP10: pp10_ff <= acc_res;
                  OP_PP11: pp11_ff <= acc_res;
                  OP_S: begin
                     s_ff <= acc_res;
                     div_num_ff <= {1'b0, abs32(pp00_ff), 16'b0};
                     div_den_ff <= abs32(acc_res);
                     div_neg_ff <= pp00_ff[31] ^ acc_res[31];
                     div_rem_ff <= '0;
                     div_cnt_ff <= DIV_STEPS;
                     div_job_ff <= JOB_K0;
                     state_ff <= S_DIV_RUN;
                  end
                  OP_PX: px_ff <= acc_res;
                  OP_PY: py_ff <= acc_res;
                  OP_RX: rx_ff <= acc_res;
                  OP_RY: ry_ff <= acc_res;
                  OP_IK0: ik0_ff <= acc_res;
                  OP_C0: p00_ff <= acc_res;
                  OP_C1: p01_ff <= acc_res;
                  OP_C2: p10_ff <= acc_res;
                  OP_C3: p11_ff <= acc_res;
                  OP_EX: est_x_ff <= acc_res;
                  OP_EY: est_y_ff <= acc_res;
                  OP_VX: vel_x_ff <= acc_res;
                  OP_VY: vel_y_ff <= acc_res;
                  OP_SQ_EX, OP_SQ_MX: sq_ff <= prod_ff[63:0];
                  OP_SQ_EY, OP_SQ_MY: begin
                     sqrt_v_ff <= sq_sum;
                     sqrt_r_ff <= '0;
                     sqrt_bit_ff <= 64'h4000_0000_0000_0000;
                     sqrt_cnt_ff <= SQRT_STEPS;
                     sqrt_second_ff <= (op_ff == OP_SQ_MY);
                     state_ff <= S_SQRT_RUN;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end

            S_SQRT_RUN: begin
               if (sqrt_ge) begin
                  sqrt_v_ff <= sqrt_v_ff - sqrt_trial;
               end
               sqrt_r_ff <= sqrt_r_next;
               sqrt_bit_ff <= sqrt_bit_ff >> 2;
               sqrt_cnt_ff <= sqrt_cnt_ff - 5'd1;
               if (sqrt_cnt_ff == 5'd0) begin
                  if (sqrt_second_ff) begin
                     state_ff <= S_CHECK;
                  end else begin
                     // hold the estimate length, go square the measurement
                     len_e_ff <= sqrt_r_next[31:0];
                     op_ff <= OP_SQ_MX;
                     state_ff <= S_MUL;
                  end
               end
            end

            S_CHECK: begin
               if (len_diff > {7'b0, dev_thr}) begin
                  if (dev_count_ff != COUNT_MAX) begin
                     dev_count_ff <= dev_count_ff + 8'd1;
                  end
               end else begin
                  dev_count_ff <= '0;
               end
               state_ff <= S_DONE;
            end

            S_DONE: begin
               if (out_free) begin
                  rsp_tdata_ff <= {vel_y_ff, vel_x_ff, est_y_ff, est_x_ff};
                  rsp_tuser_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while a measurement is in work");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE || req_fire))
      else $error("result beat raised without a finished request");

   a_visible_drop: assert property (@(posedge clock) disable iff (reset)
      ($fell(visible_ff) && $past(!reset)) |->
         $past(req_fire && req_tuser == REQ_MARK))
      else $error("target dropped without a mark request");

   a_div_in_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_END && div_job_ff == JOB_K0) |=>
         (state_ff == S_DIV_RUN && div_job_ff == JOB_K1))
      else $error("velocity gain divide not started after position gain");

endmodule
